/* rtl/svbfc_pkg.sv */
`timescale 1ns / 1ps

package svbfc_pkg;

    // Frame layout
    localparam logic [7:0] HDR_BYTE      = 8'hFF;
    localparam int         HDR_LEN       = 2;     // header bytes before the id
    localparam int         PAYLOAD_START = 5;     // position of the first payload byte
    localparam int         LEN_OFFSET    = 2;     // length byte = payload length + 2

    // Field widths fixed by the frame format
    localparam int BYTE_W   = 8;
    localparam int PLEN_W   = 7;
    localparam int PIDX_W   = 6;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 7;                  // frame position counter, wraps
    localparam int CMP_W    = 9;                  // holds MAX_PAYLOAD + PAYLOAD_START

    localparam int MAX_PAYLOAD_DEFAULT = 64;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 1'd1;

    localparam logic [BYTE_W-1:0] EXPECTED_ID_RESET    = 8'd1;
    localparam logic [PLEN_W-1:0] PAYLOAD_LENGTH_RESET = 7'd0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_HEADER   = 3'd1,
        ST_ID       = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_SERVO    = 3'd4,
        ST_CHECKSUM = 3'd5
    } t_status;

    // Output stream packing: tdata holds byte, index, status from bit 0 up
    localparam int OUT_DATA_W = 24;
    localparam int IN_DATA_W  = 8;

endpackage

/* rtl/servo_bus_status_frame_checker_top.sv */
`timescale 1ns / 1ps

// Servo bus status frame checker.
// Input stream (s_axis): one received byte per beat; tuser set drops any
// partial frame and returns to the first header byte (the byte is ignored).
// Output stream (m_axis): exactly one beat per input beat. tuser marks a
// payload byte (byte and its index in tdata); tlast marks the checksum byte,
// which carries in tdata the status of the first check that failed
// (0 ok, 1 header, 2 id, 3 length, 4 servo error, 5 checksum). When that
// status is nonzero, discard the payload bytes of that frame.
// The result of a byte appears in the cycle after its beat is taken.
// Throughput: one byte per cycle when not stalled, set by the single frame-position/checksum
// update path between the frame state registers and the output register.
// Stall: when m_axis_tready is low with a result held, s_axis_tready drops;
// the held result and the frame state stay put until the result is taken.
// Reset (synchronous, active low): expected id returns to 1, payload length
// to 0, the frame position, running sum and first fault clear, and the
// output register empties. Configuration writes (i_cfg_we) take effect at
// once and belong between frames; a length above MAX_PAYLOAD is clipped.
module servo_bus_status_frame_checker_top #(
    parameter int MAX_PAYLOAD = svbfc_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [svbfc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [svbfc_pkg::BYTE_W-1:0]          i_cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [svbfc_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
    input  logic                                  s_axis_tuser,  // [0] restart
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [7:0] payload_byte, [13:8] payload_index, [16:14] frame_status, [23:17] zero
    output logic [svbfc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tuser,  // [0] payload_valid
    output logic                                  m_axis_tlast   // frame_done
);

    localparam int PosW = svbfc_pkg::POS_W;
    localparam logic [svbfc_pkg::CMP_W-1:0] MaxLen = svbfc_pkg::CMP_W'(MAX_PAYLOAD);

    // Configuration registers
    logic [svbfc_pkg::BYTE_W-1:0] r_expected_id;
    logic [svbfc_pkg::PLEN_W-1:0] r_payload_length;

    // Frame state
    logic [PosW-1:0]              r_pos, n_pos;
    logic [svbfc_pkg::BYTE_W-1:0] r_sum, n_sum;
    svbfc_pkg::t_status           r_fault, n_fault;

    // Output register
    logic                           r_out_valid;
    logic                           r_payload_valid, n_payload_valid;
    logic [svbfc_pkg::BYTE_W-1:0]   r_payload_byte, n_payload_byte;
    logic [svbfc_pkg::PIDX_W-1:0]   r_payload_index, n_payload_index;
    logic                           r_frame_done, n_frame_done;
    svbfc_pkg::t_status             r_frame_status, n_frame_status;

    logic                           in_beat;
    logic [svbfc_pkg::BYTE_W-1:0]   rx_byte;
    logic [svbfc_pkg::CMP_W-1:0]    len_clip;
    logic [svbfc_pkg::CMP_W-1:0]    pos_ext;
    logic [svbfc_pkg::CMP_W-1:0]    pos_rel;
    svbfc_pkg::t_status             fault_now;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign rx_byte       = s_axis_tdata[svbfc_pkg::BYTE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id    <= svbfc_pkg::EXPECTED_ID_RESET;
            r_payload_length <= svbfc_pkg::PAYLOAD_LENGTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                svbfc_pkg::CFG_EXPECTED_ID:    r_expected_id    <= i_cfg_data;
                svbfc_pkg::CFG_PAYLOAD_LENGTH:
                    r_payload_length <= i_cfg_data[svbfc_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clip the configured length to MAX_PAYLOAD
    always_comb begin
        len_clip = svbfc_pkg::CMP_W'(r_payload_length);
        if (len_clip > MaxLen) begin
            len_clip = MaxLen;
        end
        pos_ext = svbfc_pkg::CMP_W'(r_pos);
        pos_rel = pos_ext - svbfc_pkg::CMP_W'(svbfc_pkg::PAYLOAD_START);
    end

    // Next frame state and the result of this byte
    always_comb begin
        n_pos           = r_pos;
        n_sum           = r_sum;
        n_fault         = r_fault;
        fault_now       = svbfc_pkg::ST_OK;
        n_payload_valid = 1'b0;
        n_payload_byte  = '0;
        n_payload_index = '0;
        n_frame_done    = 1'b0;
        n_frame_status  = svbfc_pkg::ST_OK;

        if (s_axis_tuser) begin
            // drop the partial frame
            n_pos   = '0;
            n_sum   = '0;
            n_fault = svbfc_pkg::ST_OK;
        end else if (pos_ext >= len_clip + svbfc_pkg::CMP_W'(svbfc_pkg::PAYLOAD_START)) begin
            // checksum byte: report and clear
            if (~r_sum != rx_byte) begin
                fault_now = svbfc_pkg::ST_CHECKSUM;
            end
            n_frame_done   = 1'b1;
            n_frame_status = (r_fault != svbfc_pkg::ST_OK) ? r_fault : fault_now;
            n_pos          = '0;
            n_sum          = '0;
            n_fault        = svbfc_pkg::ST_OK;
        end else begin
            if (pos_ext < svbfc_pkg::CMP_W'(svbfc_pkg::HDR_LEN)) begin
                if (rx_byte != svbfc_pkg::HDR_BYTE) begin
                    fault_now = svbfc_pkg::ST_HEADER;
                end
            end else begin
                n_sum = r_sum + rx_byte;
                case (pos_ext)
                    svbfc_pkg::CMP_W'(2): begin
                        if (rx_byte != r_expected_id) begin
                            fault_now = svbfc_pkg::ST_ID;
                        end
                    end
                    svbfc_pkg::CMP_W'(3): begin
                        if (rx_byte != svbfc_pkg::BYTE_W'(len_clip +
                                svbfc_pkg::CMP_W'(svbfc_pkg::LEN_OFFSET))) begin
                            fault_now = svbfc_pkg::ST_LENGTH;
                        end
                    end
                    svbfc_pkg::CMP_W'(4): begin
                        if (rx_byte != '0) begin
                            fault_now = svbfc_pkg::ST_SERVO;
                        end
                    end
                    default: begin
                        // pass the payload byte through
                        n_payload_valid = 1'b1;
                        n_payload_byte  = rx_byte;
                        n_payload_index = pos_rel[svbfc_pkg::PIDX_W-1:0];
                    end
                endcase
            end
            if (r_fault == svbfc_pkg::ST_OK) begin
                n_fault = fault_now;
            end
            n_pos = r_pos + PosW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sum   <= '0;
            r_fault <= svbfc_pkg::ST_OK;
        end else if (in_beat) begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_fault <= n_fault;
        end
    end

    // Output register: load on every taken beat, empty when drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_payload_valid <= n_payload_valid;
            r_payload_byte  <= n_payload_byte;
            r_payload_index <= n_payload_index;
            r_frame_done    <= n_frame_done;
            r_frame_status  <= n_frame_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_payload_valid;
    assign m_axis_tlast  = r_frame_done;
    assign m_axis_tdata  = {
        (svbfc_pkg::OUT_DATA_W - svbfc_pkg::BYTE_W - svbfc_pkg::PIDX_W
            - svbfc_pkg::STATUS_W)'(0),
        r_frame_status,
        r_payload_index,
        r_payload_byte
    };

endmodule

/* rtl/svbfc_checker.sv */
`timescale 1ns / 1ps

module svbfc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [svbfc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tuser,
    input logic                              m_axis_tlast
);

    // a payload beat is never the checksum beat
    a_payload_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser && m_axis_tlast))
        else $error("payload beat flagged as frame end");

    // status only on the checksum beat, and only a defined code
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[16:14] == 3'd0))
        else $error("status outside frame end");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:14] <= 3'd5))
        else $error("undefined frame status");

    // one result per taken byte: a taken byte always yields a beat next cycle
    a_beat_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("taken byte produced no result");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind servo_bus_status_frame_checker_top svbfc_checker u_svbfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* sim/tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the servo bus status frame checker.
module tb;

    localparam int MAX_PAYLOAD   = svbfc_pkg::MAX_PAYLOAD_DEFAULT;
    localparam int BYTE_W        = svbfc_pkg::BYTE_W;
    localparam int PIDX_W        = svbfc_pkg::PIDX_W;
    localparam int STATUS_W      = svbfc_pkg::STATUS_W;
    localparam int PLEN_W        = svbfc_pkg::PLEN_W;
    localparam int CFG_IDX_W     = svbfc_pkg::CFG_IDX_W;
    localparam int OUT_DATA_W    = svbfc_pkg::OUT_DATA_W;
    localparam int IN_DATA_W     = svbfc_pkg::IN_DATA_W;
    localparam int HDR_LEN       = svbfc_pkg::HDR_LEN;
    localparam int PAYLOAD_START = svbfc_pkg::PAYLOAD_START;
    localparam int LEN_OFFSET    = svbfc_pkg::LEN_OFFSET;
    localparam logic [7:0] HDR_BYTE = svbfc_pkg::HDR_BYTE;
    // Byte positions of the checked fields after the two header bytes
    localparam int POS_ID        = HDR_LEN;
    localparam int POS_LENGTH    = HDR_LEN + 1;
    localparam int POS_ERROR     = HDR_LEN + 2;
    // Result beat layout, low bits first: byte, index, status, zero pad
    localparam int IDX_LSB       = BYTE_W;
    localparam int ST_LSB        = BYTE_W + PIDX_W;
    localparam int PAD_LSB       = ST_LSB + STATUS_W;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 27;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int PHASE_ITEMS   = 150;
    localparam int FULL_FRAME    = 1000;   // cut point past any frame: send it whole

    // One bit per status code: corrupt that field of the frame
    localparam logic [5:0] CORRUPT_ALL = (6'(1) << svbfc_pkg::ST_HEADER) |
                                         (6'(1) << svbfc_pkg::ST_ID) |
                                         (6'(1) << svbfc_pkg::ST_LENGTH) |
                                         (6'(1) << svbfc_pkg::ST_SERVO) |
                                         (6'(1) << svbfc_pkg::ST_CHECKSUM);

    typedef struct packed {
        logic               valid;
        logic [BYTE_W-1:0]  data;
        logic [PIDX_W-1:0]  index;
        logic               done;
        svbfc_pkg::t_status status;
    } frame_result;

    // Mirror of the frame checker: its own copy of the registers and the frame
    // state, plus the results owed by the block in beat order.
    class status_frame_mirror;
        logic [BYTE_W-1:0]  exp_id;
        logic [PLEN_W-1:0]  plen_reg;
        logic [6:0]         pos;
        logic [7:0]         run_sum;
        svbfc_pkg::t_status fault;
        frame_result        owed_results[$];
        int                 bad_beats;

        function void clear_frame();
            pos     = '0;
            run_sum = '0;
            fault   = svbfc_pkg::ST_OK;
        endfunction

        function void power_on();
            exp_id   = svbfc_pkg::EXPECTED_ID_RESET;
            plen_reg = svbfc_pkg::PAYLOAD_LENGTH_RESET;
            clear_frame();
            owed_results.delete();
            bad_beats = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
            case (idx)
                svbfc_pkg::CFG_EXPECTED_ID:    exp_id   = val;
                svbfc_pkg::CFG_PAYLOAD_LENGTH: plen_reg = val[PLEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Keep only the first failed check of a frame
        function void note_fault(input svbfc_pkg::t_status code);
            if (fault == svbfc_pkg::ST_OK)
                fault = code;
        endfunction

        function void take_rx_byte(input logic [BYTE_W-1:0] rx, input logic restart);
            frame_result r;
            int unsigned len;
            int unsigned p;
            r   = '0;
            len = (plen_reg > MAX_PAYLOAD) ? MAX_PAYLOAD : plen_reg;
            p   = pos;
            if (restart) begin
                clear_frame();
            end else if (p >= len + PAYLOAD_START) begin
                // at or past the checksum slot for the current length
                if (rx != ~run_sum)
                    note_fault(svbfc_pkg::ST_CHECKSUM);
                r.done   = 1'b1;
                r.status = fault;
                clear_frame();
            end else begin
                if (p < HDR_LEN) begin
                    if (rx != HDR_BYTE)
                        note_fault(svbfc_pkg::ST_HEADER);
                end else begin
                    run_sum = run_sum + rx;
                    if (p == POS_ID) begin
                        if (rx != exp_id)
                            note_fault(svbfc_pkg::ST_ID);
                    end else if (p == POS_LENGTH) begin
                        if (rx != 8'(len + LEN_OFFSET))
                            note_fault(svbfc_pkg::ST_LENGTH);
                    end else if (p == POS_ERROR) begin
                        if (rx != 8'h00)
                            note_fault(svbfc_pkg::ST_SERVO);
                    end else begin
                        r.valid = 1'b1;
                        r.data  = rx;
                        r.index = PIDX_W'(p - PAYLOAD_START);
                    end
                end
                pos = pos + 7'd1;
            end
            owed_results.push_back(r);
        endfunction

        function void match_result_beat(input logic [OUT_DATA_W-1:0] tdata,
                                         input logic tuser, input logic tlast);
            frame_result want;
            if (owed_results.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("%0t: result beat with nothing owed: tdata=%h tuser=%b tlast=%b",
                             $time, tdata, tuser, tlast);
                return;
            end
            want = owed_results.pop_front();
            if (tuser !== want.valid || tlast !== want.done ||
                tdata[BYTE_W-1:0] !== want.data ||
                tdata[IDX_LSB +: PIDX_W] !== want.index ||
                tdata[ST_LSB +: STATUS_W] !== want.status ||
                tdata[OUT_DATA_W-1:PAD_LSB] !== '0) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display({"%0t: mismatch: want valid=%b byte=%h idx=%0d done=%b st=%0d, ",
                              "got valid=%b byte=%h idx=%0d done=%b st=%0d pad=%h"},
                             $time, want.valid, want.data, want.index, want.done,
                             want.status, tuser, tdata[BYTE_W-1:0], tdata[IDX_LSB +: PIDX_W],
                             tlast, tdata[ST_LSB +: STATUS_W], tdata[OUT_DATA_W-1:PAD_LSB]);
            end
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [BYTE_W-1:0]      i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;   // [7:0] rx_byte
    logic                   s_axis_tuser  = 1'b0; // [0] restart
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;         // [7:0] byte, [13:8] index, [16:14] status
    logic                   m_axis_tuser;         // [0] payload_valid
    logic                   m_axis_tlast;         // frame_done

    status_frame_mirror     mirror;
    int                     src_idle_pct  = IDLE_PCT;
    int                     sink_idle_pct = IDLE_PCT;
    int unsigned            items_sent    = 0;
    int unsigned            cycle_count   = 0;
    // Stimulus-side copy of the registers, used to build well-formed frames
    logic [BYTE_W-1:0]      cur_id        = svbfc_pkg::EXPECTED_ID_RESET;
    logic [PLEN_W-1:0]      cur_plen      = svbfc_pkg::PAYLOAD_LENGTH_RESET;

    servo_bus_status_frame_checker_top #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Throttle the result side at random; a zero rate keeps tready high.
    always @(negedge i_clk) begin
        m_axis_tready <= (sink_idle_pct == 0) || ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Sample both handshakes at the rising edge: note the input beat first,
    // then check the result beat against the oldest owed result.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                mirror.take_rx_byte(s_axis_tdata[BYTE_W-1:0], s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                mirror.match_result_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Present one beat from a falling edge and hold it until taken. Each
    // cycle idles at the configured rate before the beat goes out. Leave
    // tvalid high on return so back-to-back beats need no second assignment.
    task automatic send_beat(input logic [BYTE_W-1:0] rx, input logic restart);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(0, 99) < src_idle_pct)
                @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        s_axis_tuser  <= restart;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Drop tvalid and wait until every owed result has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (mirror.owed_results.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Write one register while the block is idle; mirror it at once. Drop
    // the write enable before returning so writes never overlap.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mirror.write_reg(idx, val);
        if (idx == svbfc_pkg::CFG_EXPECTED_ID)
            cur_id = val;
        else
            cur_plen = val[PLEN_W-1:0];
        @(negedge i_clk);
    endtask

    // Build a status frame for the current settings with n_payload payload
    // bytes, corrupt the fields flagged in corrupt, and send its first cut
    // bytes. A cut frame is closed with a restart beat.
    task automatic send_status_frame(input logic [5:0] corrupt, input int unsigned n_payload,
                                     input int unsigned cut);
        logic [BYTE_W-1:0] fr[$];
        logic [BYTE_W-1:0] chk;
        int unsigned       len;
        int unsigned       k;
        len = (cur_plen > MAX_PAYLOAD) ? MAX_PAYLOAD : cur_plen;
        fr  = {HDR_BYTE, HDR_BYTE, cur_id, 8'(len + LEN_OFFSET), 8'h00};
        repeat (n_payload) fr.push_back(8'($urandom()));
        if (corrupt[svbfc_pkg::ST_HEADER]) begin
            k     = $urandom_range(0, HDR_LEN - 1);
            fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
        end
        if (corrupt[svbfc_pkg::ST_ID])
            fr[POS_ID] = fr[POS_ID] ^ 8'($urandom_range(1, 255));
        if (corrupt[svbfc_pkg::ST_LENGTH])
            fr[POS_LENGTH] = fr[POS_LENGTH] ^ 8'($urandom_range(1, 255));
        if (corrupt[svbfc_pkg::ST_SERVO])
            fr[POS_ERROR] = 8'($urandom_range(1, 255));
        chk = '0;
        for (int i = POS_ID; i < fr.size(); i++)
            chk = chk + fr[i];
        chk = ~chk;
        if (corrupt[svbfc_pkg::ST_CHECKSUM])
            chk = chk ^ 8'($urandom_range(1, 255));
        fr.push_back(chk);
        for (int i = 0; i < fr.size() && i < cut; i++)
            send_beat(fr[i], 1'b0);
        if (cut < fr.size())
            send_beat(8'($urandom()), 1'b1);
    endtask

    // Mostly clean frames with random payload; the rest carry one or more
    // bad fields, a wrong payload count, a cut-off, or plain line noise.
    // Every case that loses alignment ends with a restart beat.
    task automatic run_phase(input int unsigned budget);
        int unsigned stop_at;
        int unsigned len;
        int unsigned pick;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            len  = (cur_plen > MAX_PAYLOAD) ? MAX_PAYLOAD : cur_plen;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_status_frame('0, len, FULL_FRAME);
            end else if (pick < 75) begin
                send_status_frame(6'(1) << $urandom_range(svbfc_pkg::ST_HEADER,
                                                          svbfc_pkg::ST_CHECKSUM),
                                  len, FULL_FRAME);
            end else if (pick < 80) begin
                send_status_frame(6'($urandom()) & CORRUPT_ALL, len, FULL_FRAME);
            end else if (pick < 87) begin
                send_status_frame('0, $urandom_range(0, len + 3), FULL_FRAME);
                send_beat(8'($urandom()), 1'b1);
            end else if (pick < 94) begin
                send_status_frame('0, len, $urandom_range(0, len + PAYLOAD_START));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_beat(8'($urandom()), $urandom_range(0, 7) == 0);
                send_beat(8'($urandom()), 1'b1);
            end
        end
    endtask

    initial begin
        int unsigned random_start;
        int unsigned phase_no;
        logic [PLEN_W-1:0] plen_pick;

        mirror = new;
        mirror.power_on();
        // Hold reset, then release it on a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset settings (id 1, no payload) first.
        send_status_frame('0, 0, FULL_FRAME);            // clean frame
        send_status_frame(CORRUPT_ALL, 0, FULL_FRAME);   // every field bad: header wins
        send_beat(HDR_BYTE, 1'b0);                       // restart inside the header
        send_beat(8'h00, 1'b1);
        // Change the length mid-frame: stop after one payload byte, shorten
        // to zero, and the next byte lands past the checksum slot.
        wait_drained();
        write_reg(svbfc_pkg::CFG_PAYLOAD_LENGTH, 8'd1);
        send_beat(HDR_BYTE, 1'b0);
        send_beat(HDR_BYTE, 1'b0);
        send_beat(cur_id, 1'b0);
        send_beat(8'd3, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        wait_drained();
        write_reg(svbfc_pkg::CFG_PAYLOAD_LENGTH, 8'd0);
        send_beat(8'h00, 1'b0);
        wait_drained();

        // Random phases; settle the block and rewrite both registers between
        // them. Early phases hit the extremes, including lengths that clip.
        random_start = items_sent;
        phase_no     = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            case (phase_no)
                0: begin
                    write_reg(svbfc_pkg::CFG_EXPECTED_ID, 8'd0);
                    plen_pick = 7'd0;
                end
                1: begin
                    write_reg(svbfc_pkg::CFG_EXPECTED_ID, 8'd255);
                    plen_pick = 7'd64;
                end
                2: begin
                    write_reg(svbfc_pkg::CFG_EXPECTED_ID, 8'($urandom()));
                    plen_pick = 7'd127;
                end
                3: begin
                    write_reg(svbfc_pkg::CFG_EXPECTED_ID, 8'($urandom()));
                    plen_pick = 7'd65;
                end
                default: begin
                    write_reg(svbfc_pkg::CFG_EXPECTED_ID, 8'($urandom()));
                    case ($urandom_range(0, 9))
                        0:       plen_pick = 7'd64;
                        1:       plen_pick = 7'($urandom_range(65, 127));
                        default: plen_pick = 7'($urandom_range(0, 8));
                    endcase
                end
            endcase
            write_reg(svbfc_pkg::CFG_PAYLOAD_LENGTH, {1'b0, plen_pick});
            // One phase runs with no idling on either side
            src_idle_pct  = (phase_no == 4) ? 0 : IDLE_PCT;
            sink_idle_pct = (phase_no == 4) ? 0 : IDLE_PCT;
            run_phase(PHASE_ITEMS);
            wait_drained();
            phase_no++;
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (mirror.bad_beats == 0 && mirror.owed_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* servo_bus_status_frame_checker_top.f */
rtl/svbfc_pkg.sv
rtl/servo_bus_status_frame_checker_top.sv
rtl/svbfc_checker.sv
sim/tb.sv
